[hdl/efcs_pkg.sv]
// shared types and constants for the four-center search
package efcs_pkg;
    localparam int MAX_PTS_DEF = 64;
    localparam int CRD_W = 16;
    localparam int DSQ_W = 33;
    localparam int ROOT_W = 17;
    localparam int IDX_W = 11;
    localparam int CNT_W = 12;
    localparam int TRY_W = 40;
    localparam int STAT_W = 2;

    localparam logic [STAT_W-1:0] ST_OK = 2'd0;
    localparam logic [STAT_W-1:0] ST_FEW = 2'd1;
    localparam logic [STAT_W-1:0] ST_OVF = 2'd2;

    typedef struct packed {
        logic store;
        logic first;
        logic root_go;
    } efcs_cmd_t;

    typedef struct packed {
        logic ovf;
        logic few;
        logic search_done;
        logic root_done;
    } efcs_sts_t;
endpackage

[hdl/efcs_ctrl.sv]
// control state machine for load, search, root and output
module efcs_ctrl
    import efcs_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                last_point,
    output logic                in_stall,
    input  logic                out_stall,
    output logic                out_valid,
    output logic [STAT_W-1:0]   out_status,
    output efcs_cmd_t           cmd,
    input  efcs_sts_t           sts
);
    typedef enum logic [4:0] {
        S_LOAD = 5'b00001,
        S_SRCH = 5'b00010,
        S_ROOT = 5'b00100,
        S_OUT  = 5'b01000,
        S_WAIT = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic [STAT_W-1:0] stat_reg, stat_next;
    logic acc;

    assign in_stall = (state_reg != S_LOAD);
    assign acc = in_valid && !in_stall;
    assign out_valid = (state_reg == S_OUT);
    assign out_status = stat_reg;

    always_comb
    begin
        state_next = state_reg;
        stat_next = stat_reg;
        cmd = '0;
        case (state_reg)
            S_LOAD:
            begin
                if (acc)
                begin
                    cmd.store = 1'b1;
                    if (last_point)
                    begin
                        state_next = S_WAIT;
                    end
                end
            end
            S_WAIT:
            begin
                if (sts.ovf)
                begin
                    stat_next = ST_OVF;
                    state_next = S_OUT;
                end
                else if (sts.few)
                begin
                    stat_next = ST_FEW;
                    state_next = S_OUT;
                end
                else
                begin
                    stat_next = ST_OK;
                    cmd.first = 1'b1;
                    state_next = S_SRCH;
                end
            end
            S_SRCH:
            begin
                if (sts.search_done)
                begin
                    state_next = S_ROOT;
                end
            end
            S_ROOT:
            begin
                cmd.root_go = 1'b1;
                if (sts.root_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            stat_reg <= ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            stat_reg <= stat_next;
        end
    end
endmodule

[hdl/efcs_dp.sv]
// point store, tuple walk, cost evaluation and square root
module efcs_dp
    import efcs_pkg::*;
#(
    parameter int MAX_PTS = MAX_PTS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic signed [CRD_W-1:0]  point_x,
    input  logic signed [CRD_W-1:0]  point_y,
    input  efcs_cmd_t                cmd,
    input  logic                     out_fire,
    input  logic [STAT_W-1:0]        out_status,
    output efcs_sts_t                sts,
    output logic [DSQ_W-1:0]         cost_squared,
    output logic [ROOT_W-1:0]        cost_root,
    output logic [IDX_W-1:0]         center_a,
    output logic [IDX_W-1:0]         center_b,
    output logic [IDX_W-1:0]         center_c,
    output logic [IDX_W-1:0]         center_d,
    output logic [TRY_W-1:0]         tuples_tried
);
    localparam int AW = (MAX_PTS > 2) ? $clog2(MAX_PTS) : 1;

    // five copies of the store, one read port per center plus one for the point
    logic [2*CRD_W-1:0] mem_p [MAX_PTS];
    logic [2*CRD_W-1:0] mem_c [4][MAX_PTS];

    logic [CNT_W-1:0] cnt_reg;
    logic ovf_reg;

    // tuple and point indices
    logic [IDX_W-1:0] ti_reg, tj_reg, tk_reg, tl_reg, tp_reg;
    logic [CNT_W-1:0] n_reg;
    // pipeline: read, then diffs, then squares, then min/max
    logic v1_reg, v2_reg, v3_reg, lastp1_reg, lastp2_reg, lastp3_reg;
    logic [2*CRD_W-1:0] rp_reg;
    logic [2*CRD_W-1:0] rc_reg [4];
    logic signed [CRD_W:0] dx_reg [4];
    logic signed [CRD_W:0] dy_reg [4];
    logic [DSQ_W-1:0] d2_reg [4];
    logic [DSQ_W-1:0] cost_reg, best_reg;
    logic have_reg, busy_reg, issue_reg, fin_reg;
    logic [IDX_W-1:0] bc_reg [4];
    logic [IDX_W-1:0] tc1_reg [4];
    logic [IDX_W-1:0] tc2_reg [4];
    logic [IDX_W-1:0] tc3_reg [4];
    logic [TRY_W-1:0] tried_reg;

    // root unit
    logic [DSQ_W+1:0] rv_reg, rres_reg, rbit_reg;
    logic rrun_reg, rdone_reg;

    logic [AW-1:0] wa;
    assign wa = cnt_reg[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.store && (cnt_reg < CNT_W'(MAX_PTS)))
        begin
            mem_p[wa] <= {point_y, point_x};
            for (int c = 0; c < 4; c++)
            begin
                mem_c[c][wa] <= {point_y, point_x};
            end
        end
        rp_reg <= mem_p[tp_reg[AW-1:0]];
        rc_reg[0] <= mem_c[0][ti_reg[AW-1:0]];
        rc_reg[1] <= mem_c[1][tj_reg[AW-1:0]];
        rc_reg[2] <= mem_c[2][tk_reg[AW-1:0]];
        rc_reg[3] <= mem_c[3][tl_reg[AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else if (out_fire)
        begin
            cnt_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else if (cmd.store)
        begin
            if (cnt_reg < CNT_W'(MAX_PTS))
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else
            begin
                ovf_reg <= 1'b1;
            end
        end
    end

    assign sts.ovf = ovf_reg;
    assign sts.few = (cnt_reg < CNT_W'(4));
    assign sts.search_done = fin_reg;
    assign sts.root_done = rdone_reg;

    // index walk and pipeline
    logic p_last, l_last, k_last, j_last, i_last, abort;
    logic [CNT_W-1:0] pn, ln, kn, jn;
    assign pn = {1'b0, tp_reg} + 1'b1;
    assign ln = {1'b0, tl_reg} + 1'b1;
    assign kn = {1'b0, tk_reg} + 1'b1;
    assign jn = {1'b0, tj_reg} + 1'b1;
    assign p_last = (pn == n_reg);
    assign l_last = (ln == n_reg);
    assign k_last = (kn + 1'b1 == n_reg);
    assign j_last = (jn + 2'd2 == n_reg);
    assign i_last = ({1'b0, ti_reg} + 3'd4 == n_reg);

    logic [DSQ_W-1:0] m01, m23, mmin, cnew;
    assign m01 = (d2_reg[1] < d2_reg[0]) ? d2_reg[1] : d2_reg[0];
    assign m23 = (d2_reg[3] < d2_reg[2]) ? d2_reg[3] : d2_reg[2];
    assign mmin = (m23 < m01) ? m23 : m01;
    assign cnew = (mmin > cost_reg) ? mmin : cost_reg;
    // early exit once this tuple can no longer win
    assign abort = v3_reg && have_reg && (cnew >= best_reg);

    // tuple advances when a tuple ends; this tuple's indices live in tc3
    logic fin_pending;
    logic tuple_end;
    logic tuple_last_reg;
    assign tuple_end = abort || (v3_reg && lastp3_reg);
    assign fin_pending = tuple_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            issue_reg <= 1'b0;
            fin_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            have_reg <= 1'b0;
        end
        else
        begin
            fin_reg <= 1'b0;
            if (cmd.first)
            begin
                busy_reg <= 1'b1;
                issue_reg <= 1'b1;
                have_reg <= 1'b0;
                v1_reg <= 1'b0;
                v2_reg <= 1'b0;
                v3_reg <= 1'b0;
            end
            else if (busy_reg)
            begin
                v1_reg <= issue_reg && !abort;
                v2_reg <= v1_reg && !abort;
                v3_reg <= v2_reg && !abort;
                if (abort)
                begin
                    issue_reg <= 1'b1;
                    if (fin_pending)
                    begin
                        busy_reg <= 1'b0;
                        issue_reg <= 1'b0;
                        fin_reg <= 1'b1;
                    end
                end
                else
                begin
                    if (issue_reg && p_last)
                    begin
                        issue_reg <= 1'b0;
                    end
                    if (v3_reg && lastp3_reg)
                    begin
                        have_reg <= 1'b1;
                        issue_reg <= 1'b1;
                        if (fin_pending)
                        begin
                            busy_reg <= 1'b0;
                            issue_reg <= 1'b0;
                            fin_reg <= 1'b1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.first)
        begin
            n_reg <= cnt_reg;
            ti_reg <= IDX_W'(0);
            tj_reg <= IDX_W'(1);
            tk_reg <= IDX_W'(2);
            tl_reg <= IDX_W'(3);
            tp_reg <= '0;
            cost_reg <= '0;
            tried_reg <= '0;
            tuple_last_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            if (issue_reg && !abort && !p_last)
            begin
                tp_reg <= pn[IDX_W-1:0];
            end
            lastp1_reg <= p_last;
            lastp2_reg <= lastp1_reg;
            lastp3_reg <= lastp2_reg;
            for (int c = 0; c < 4; c++)
            begin
                tc2_reg[c] <= tc1_reg[c];
                tc3_reg[c] <= tc2_reg[c];
                dx_reg[c] <= (CRD_W+1)'($signed(rp_reg[CRD_W-1:0]))
                    - (CRD_W+1)'($signed(rc_reg[c][CRD_W-1:0]));
                dy_reg[c] <= (CRD_W+1)'($signed(rp_reg[2*CRD_W-1:CRD_W]))
                    - (CRD_W+1)'($signed(rc_reg[c][2*CRD_W-1:CRD_W]));
                d2_reg[c] <= DSQ_W'(dx_reg[c] * dx_reg[c])
                    + DSQ_W'(dy_reg[c] * dy_reg[c]);
            end
            tc1_reg[0] <= ti_reg;
            tc1_reg[1] <= tj_reg;
            tc1_reg[2] <= tk_reg;
            tc1_reg[3] <= tl_reg;
            if (v3_reg)
            begin
                cost_reg <= cnew;
            end
            if (tuple_end)
            begin
                cost_reg <= '0;
                tried_reg <= tried_reg + 1'b1;
                tp_reg <= '0;
                if (!abort && (!have_reg || cnew < best_reg))
                begin
                    best_reg <= cnew;
                    for (int c = 0; c < 4; c++)
                    begin
                        bc_reg[c] <= tc3_reg[c];
                    end
                end
                if (!l_last)
                begin
                    tl_reg <= ln[IDX_W-1:0];
                end
                else if (!k_last)
                begin
                    tk_reg <= kn[IDX_W-1:0];
                    tl_reg <= kn[IDX_W-1:0] + 1'b1;
                end
                else if (!j_last)
                begin
                    tj_reg <= jn[IDX_W-1:0];
                    tk_reg <= jn[IDX_W-1:0] + 1'b1;
                    tl_reg <= jn[IDX_W-1:0] + 2'd2;
                end
                else
                begin
                    ti_reg <= ti_reg + 1'b1;
                    tj_reg <= ti_reg + 2'd2;
                    tk_reg <= ti_reg + 2'd3;
                    tl_reg <= ti_reg + 3'd4;
                end
                tuple_last_reg <= 1'b0;
            end
            if (!tuple_end)
            begin
                tuple_last_reg <= l_last && k_last && j_last && i_last;
            end
        end
    end

    // bit-pair restoring square root, one step per cycle
    logic [DSQ_W+1:0] rsum;
    assign rsum = rres_reg + rbit_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rrun_reg <= 1'b0;
            rdone_reg <= 1'b0;
        end
        else
        begin
            rdone_reg <= 1'b0;
            if (cmd.root_go && !rrun_reg && !rdone_reg)
            begin
                rrun_reg <= 1'b1;
                rv_reg <= (DSQ_W+2)'(best_reg);
                rres_reg <= '0;
                rbit_reg <= (DSQ_W+2)'(1) << (DSQ_W+1);
            end
            else if (rrun_reg)
            begin
                if (rbit_reg == '0)
                begin
                    rrun_reg <= 1'b0;
                    rdone_reg <= 1'b1;
                end
                else
                begin
                    if (rv_reg >= rsum)
                    begin
                        rv_reg <= rv_reg - rsum;
                        rres_reg <= (rres_reg >> 1) + rbit_reg;
                    end
                    else
                    begin
                        rres_reg <= rres_reg >> 1;
                    end
                    rbit_reg <= rbit_reg >> 2;
                end
            end
        end
    end

    logic ok;
    assign ok = (out_status == ST_OK);
    assign cost_squared = ok ? best_reg : '0;
    assign cost_root = ok ? rres_reg[ROOT_W-1:0] : '0;
    assign center_a = ok ? bc_reg[0] : '0;
    assign center_b = ok ? bc_reg[1] : '0;
    assign center_c = ok ? bc_reg[2] : '0;
    assign center_d = ok ? bc_reg[3] : '0;
    assign tuples_tried = ok ? tried_reg : '0;
endmodule

[hdl/exact_four_center_search.sv]
// exact four-center search, top level
// sequence: n points are loaded and checked, then every tuple is searched with early
// exit per tuple, then the square root of the best cost is taken
// too few points or overflow: result in the cycle after the check state
// throughput: one point item per cycle while loading; one search at a time
// reset: rst_n asynchronous active low clears point count, overflow flag and control
module exact_four_center_search
    import efcs_pkg::*;
#(
    parameter int MAX_PTS = MAX_PTS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic signed [CRD_W-1:0]  point_x,
    input  logic signed [CRD_W-1:0]  point_y,
    input  logic                     last_point,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [STAT_W-1:0]        status,
    output logic [DSQ_W-1:0]         cost_squared,
    output logic [ROOT_W-1:0]        cost_root,
    output logic [IDX_W-1:0]         center_a,
    output logic [IDX_W-1:0]         center_b,
    output logic [IDX_W-1:0]         center_c,
    output logic [IDX_W-1:0]         center_d,
    output logic [TRY_W-1:0]         tuples_tried
);
    efcs_cmd_t cmd;
    efcs_sts_t sts;

    efcs_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .last_point (last_point),
        .in_stall   (in_stall),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .out_status (status),
        .cmd        (cmd),
        .sts        (sts)
    );

    efcs_dp #(
        .MAX_PTS (MAX_PTS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .point_x      (point_x),
        .point_y      (point_y),
        .cmd          (cmd),
        .out_fire     (out_valid && !out_stall),
        .out_status   (status),
        .sts          (sts),
        .cost_squared (cost_squared),
        .cost_root    (cost_root),
        .center_a     (center_a),
        .center_b     (center_b),
        .center_c     (center_c),
        .center_d     (center_d),
        .tuples_tried (tuples_tried)
    );
endmodule

[sim/tb_exact_four_center_search.sv]
// testbench for the exact four-center search: random point sets, scoreboard check
module tb_exact_four_center_search;
    import efcs_pkg::*;

    localparam int NPTS = MAX_PTS_DEF;
    localparam int IDLE_LIMIT = 200000;

    typedef struct {
        logic [STAT_W-1:0] status;
        logic [DSQ_W-1:0]  cost_squared;
        logic [ROOT_W-1:0] cost_root;
        logic [IDX_W-1:0]  ctr [4];
        logic [TRY_W-1:0]  tuples_tried;
    } cover_result_t;

    class cover_scoreboard;
        logic [2*CRD_W-1:0] pts [NPTS];
        int unsigned        npts;
        bit                 ovf;
        cover_result_t      expected [$];
        int unsigned        fails;
        int unsigned        seen [3];

        function new();
            npts = 0;
            ovf = 0;
            fails = 0;
            seen = '{0, 0, 0};
        endfunction

        function longint unsigned dist2(logic [2*CRD_W-1:0] a, logic [2*CRD_W-1:0] b);
            longint dx;
            longint dy;
            dx = longint'($signed(a[CRD_W-1:0])) - longint'($signed(b[CRD_W-1:0]));
            dy = longint'($signed(a[2*CRD_W-1:CRD_W])) - longint'($signed(b[2*CRD_W-1:CRD_W]));
            return longint'(dx * dx + dy * dy);
        endfunction

        function longint unsigned int_root(longint unsigned v);
            longint unsigned res;
            longint unsigned b;
            res = 0;
            b = 64'd1 << 62;
            while (b > v)
                b >>= 2;
            while (b != 0)
            begin
                if (v >= res + b)
                begin
                    v -= res + b;
                    res = (res >> 1) + b;
                end
                else
                    res >>= 1;
                b >>= 2;
            end
            return res;
        endfunction

        function void search(ref cover_result_t r);
            longint unsigned d [NPTS][NPTS];
            longint unsigned best;
            longint unsigned cost;
            longint unsigned m;
            longint unsigned tried;
            bit have;
            bit worse;
            best = 0;
            tried = 0;
            have = 0;
            for (int p = 0; p < npts; p++)
                for (int q = 0; q < npts; q++)
                    d[p][q] = dist2(pts[p], pts[q]);
            for (int i = 0; i + 3 < npts; i++)
                for (int j = i + 1; j + 2 < npts; j++)
                    for (int k = j + 1; k + 1 < npts; k++)
                        for (int l = k + 1; l < npts; l++)
                        begin
                            cost = 0;
                            worse = 0;
                            tried++;
                            for (int p = 0; p < npts; p++)
                            begin
                                m = d[p][i];
                                if (d[p][j] < m) m = d[p][j];
                                if (d[p][k] < m) m = d[p][k];
                                if (d[p][l] < m) m = d[p][l];
                                if (m > cost) cost = m;
                                if (have && cost >= best)
                                begin
                                    worse = 1;
                                    break;
                                end
                            end
                            if (!worse && (!have || cost < best))
                            begin
                                have = 1;
                                best = cost;
                                r.ctr = '{IDX_W'(i), IDX_W'(j), IDX_W'(k), IDX_W'(l)};
                            end
                        end
            r.cost_squared = DSQ_W'(best);
            r.cost_root = ROOT_W'(int_root(best));
            r.tuples_tried = TRY_W'(tried);
        endfunction

        function void note_point(logic signed [CRD_W-1:0] x, logic signed [CRD_W-1:0] y,
                                 logic last);
            cover_result_t r;
            if (npts < NPTS)
            begin
                pts[npts] = {y, x};
                npts++;
            end
            else
                ovf = 1;
            if (!last)
                return;
            r.status = ST_OK;
            r.cost_squared = '0;
            r.cost_root = '0;
            r.ctr = '{'0, '0, '0, '0};
            r.tuples_tried = '0;
            if (ovf)
                r.status = ST_OVF;
            else if (npts < 4)
                r.status = ST_FEW;
            else
                search(r);
            expected.push_back(r);
            npts = 0;
            ovf = 0;
        endfunction

        function void check_result(cover_result_t got);
            cover_result_t e;
            string nm [4] = '{"center_a", "center_b", "center_c", "center_d"};
            if (expected.size() == 0)
            begin
                $error("unexpected result, status %0d", got.status);
                fails++;
                return;
            end
            e = expected.pop_front();
            if (e.status <= ST_OVF)
                seen[e.status]++;
            if (got.status !== e.status)
            begin
                $error("status expected %0d got %0d", e.status, got.status);
                fails++;
            end
            if (got.cost_squared !== e.cost_squared)
            begin
                $error("cost_squared expected %0d got %0d", e.cost_squared, got.cost_squared);
                fails++;
            end
            if (got.cost_root !== e.cost_root)
            begin
                $error("cost_root expected %0d got %0d", e.cost_root, got.cost_root);
                fails++;
            end
            for (int c = 0; c < 4; c++)
                if (got.ctr[c] !== e.ctr[c])
                begin
                    $error("%s expected %0d got %0d", nm[c], e.ctr[c], got.ctr[c]);
                    fails++;
                end
            if (got.tuples_tried !== e.tuples_tried)
            begin
                $error("tuples_tried expected %0d got %0d", e.tuples_tried, got.tuples_tried);
                fails++;
            end
        endfunction
    endclass

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_stall;
    logic signed [CRD_W-1:0] point_x;
    logic signed [CRD_W-1:0] point_y;
    logic                    last_point;
    logic                    out_valid;
    logic                    out_stall;
    logic [STAT_W-1:0]       status;
    logic [DSQ_W-1:0]        cost_squared;
    logic [ROOT_W-1:0]       cost_root;
    logic [IDX_W-1:0]        center_a;
    logic [IDX_W-1:0]        center_b;
    logic [IDX_W-1:0]        center_c;
    logic [IDX_W-1:0]        center_d;
    logic [TRY_W-1:0]        tuples_tried;

    cover_scoreboard sb = new();
    bit              hold_req;
    int unsigned     idle_cycles;
    int unsigned     burst_left;
    int unsigned     sets_sent;
    int unsigned     items_sent;

    exact_four_center_search i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .point_x      (point_x),
        .point_y      (point_y),
        .last_point   (last_point),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .cost_squared (cost_squared),
        .cost_root    (cost_root),
        .center_a     (center_a),
        .center_b     (center_b),
        .center_c     (center_c),
        .center_d     (center_d),
        .tuples_tried (tuples_tried)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // input and output monitors
    always @(posedge clk)
    begin
        cover_result_t r;
        if (rst_n && in_valid && !in_stall)
            sb.note_point(point_x, point_y, last_point);
        if (rst_n && out_valid && !out_stall)
        begin
            r.status = status;
            r.cost_squared = cost_squared;
            r.cost_root = cost_root;
            r.ctr = '{center_a, center_b, center_c, center_d};
            r.tuples_tried = tuples_tried;
            sb.check_result(r);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // receiver stall pattern, with one long hold on request
    initial
    begin
        int mode;
        bit held;
        held = 0;
        out_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req && !held)
            begin
                out_stall <= 1'b1;
                repeat (400) @(posedge clk);
                held = 1;
            end
            mode = $urandom_range(0, 3);
            repeat (24)
            begin
                @(posedge clk);
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    2: out_stall <= ($urandom_range(0, 1) == 0);
                    default: out_stall <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    task automatic send_point(input logic signed [CRD_W-1:0] x,
                              input logic signed [CRD_W-1:0] y, input logic last);
        int gap;
        in_valid <= 1'b1;
        point_x <= x;
        point_y <= y;
        last_point <= last;
        do
            @(posedge clk);
        while (in_stall);
        items_sent++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 12);
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // coordinates either anywhere on the grid or in a small cluster that makes ties
    task automatic send_set(input int n, input bit clustered);
        logic signed [CRD_W-1:0] x;
        logic signed [CRD_W-1:0] y;
        for (int p = 0; p < n; p++)
        begin
            if (clustered)
            begin
                x = $signed(CRD_W'($urandom_range(0, 15))) - 16'sd8;
                y = $signed(CRD_W'($urandom_range(0, 15))) - 16'sd8;
            end
            else
            begin
                x = CRD_W'($urandom());
                y = CRD_W'($urandom());
            end
            send_point(x, y, p == n - 1);
        end
        sets_sent++;
    endtask

    initial
    begin
        int n;
        rst_n = 1'b0;
        in_valid <= 1'b0;
        point_x <= '0;
        point_y <= '0;
        last_point <= 1'b0;
        hold_req = 0;
        burst_left = 0;
        sets_sent = 0;
        items_sent = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // grid corners plus origin
        send_point(-16'sd32768, -16'sd32768, 1'b0);
        send_point(16'sd32767, 16'sd32767, 1'b0);
        send_point(-16'sd32768, 16'sd32767, 1'b0);
        send_point(16'sd32767, -16'sd32768, 1'b0);
        send_point(16'sd0, 16'sd0, 1'b1);
        // single point and three points: too few
        send_point(16'sd5, -16'sd5, 1'b1);
        send_point(16'sd1, 16'sd2, 1'b0);
        send_point(16'sd3, 16'sd4, 1'b0);
        send_point(-16'sd1, 16'sd0, 1'b1);
        // exactly four points, then duplicates giving zero cost
        send_point(16'sd100, 16'sd0, 1'b0);
        send_point(-16'sd100, 16'sd0, 1'b0);
        send_point(16'sd0, 16'sd100, 1'b0);
        send_point(16'sd0, -16'sd100, 1'b1);
        repeat (5) send_point(16'sd7, 16'sd7, 1'b0);
        send_point(16'sd7, 16'sd7, 1'b1);
        // store overflow
        send_set(NPTS + 1, 0);
        send_set(NPTS + 3, 1);

        // block fills while the receiver holds off
        hold_req = 1;
        repeat (6) send_set(4, 1);

        while (items_sent < 1790)
        begin
            n = $urandom_range(0, 19) == 0 ? $urandom_range(1, 3) : $urandom_range(4, 9);
            if ($urandom_range(0, 49) == 0)
                n = 12;
            send_set(n, $urandom_range(0, 2) == 0);
        end
        send_set(NPTS + 1, 0);
        in_valid <= 1'b0;

        while (sb.expected.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);

        $display("%0d point items in %0d sets; results ok %0d, too few %0d, overflow %0d",
                 items_sent, sets_sent, sb.seen[0], sb.seen[1], sb.seen[2]);
        if (sb.fails == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

[files.f]
hdl/efcs_pkg.sv
hdl/efcs_ctrl.sv
hdl/efcs_dp.sv
hdl/exact_four_center_search.sv
sim/tb_exact_four_center_search.sv
